// ----- hdl/kcl_pkg.sv -----
// Package for the keypad code lock with card reset.
// Holds the item and result types, register indexes, key codes and the
// scan pattern decoder. No dependencies.
`default_nettype none

package kcl_pkg;

  localparam int unsigned CARD_ID_W   = 48;
  localparam int unsigned CARD_ID_ALL = 2 * CARD_ID_W;
  localparam int unsigned APB_ADDR_W  = 4;
  localparam int unsigned APB_DATA_W  = 64;
  localparam int unsigned KEY_COUNT   = 12;

  localparam logic [CARD_ID_W-1:0] CARD_ID_HIGH_RST = 48'd55195450291252;
  localparam logic [CARD_ID_W-1:0] CARD_ID_LOW_RST  = 48'd61805455357236;

  localparam logic [3:0] NO_KEY     = 4'd15;
  localparam logic [3:0] MAX_DIGIT  = 4'd9;
  localparam logic [3:0] KEY_CLEAR  = 4'd10;
  localparam logic [3:0] KEY_CARD   = 4'd11;
  localparam logic [3:0] CODE_RST   = 4'd1;

  // Scan pattern of each key, bit 0 cleared.
  localparam logic [7:0] KEY_PATTERN [KEY_COUNT] = '{
    8'hEA, 8'h76, 8'h7A, 8'h7C, 8'hB6, 8'hBA,
    8'hBC, 8'hD6, 8'hDA, 8'hDC, 8'hE6, 8'hEC
  };

  typedef enum logic [1:0] {
    MODE_NORMAL  = 2'd0,
    MODE_CARD    = 2'd1,
    MODE_NEWCODE = 2'd2
  } kcl_mode_e;

  // Register index, taken from paddr bit 3 (8-byte register spacing).
  typedef enum logic [0:0] {
    REG_CARD_ID_HIGH = 1'b0,
    REG_CARD_ID_LOW  = 1'b1
  } kcl_reg_e;

  typedef struct packed {
    logic       func;
    logic [7:0] key_pattern;
    logic [7:0] reader_byte;
  } kcl_item_t;

  typedef struct packed {
    logic [3:0] key_value;
    logic       unlock;
    logic [1:0] lock_mode;
    logic       card_accepted;
    logic       card_rejected;
    logic       code_changed;
  } kcl_result_t;

  function automatic logic [3:0] decode_key(input logic [7:0] pattern);
    logic [7:0] p;
    logic [3:0] key;
    p   = {pattern[7:1], 1'b0};
    key = NO_KEY;
    for (int k = KEY_COUNT - 1; k >= 0; k--) begin
      if (KEY_PATTERN[k] == p) begin
        key = 4'(k);
      end
    end
    return key;
  endfunction

  // Byte pos of the card ID, byte 0 in the top bits. pos stays below 12.
  function automatic logic [7:0] expected_byte(input logic [CARD_ID_ALL-1:0] id,
                                               input logic [3:0] pos);
    logic [11:0][7:0] bytes;
    bytes = id;
    return bytes[4'd11 - pos];
  endfunction

endpackage

`default_nettype wire

// ----- hdl/kcl_if.sv -----
// Valid/ready channel interfaces for input items and result items.
// No dependencies; its field widths are kept in step with kcl_pkg.
`default_nettype none

interface kcl_in_if;
  logic       valid;
  logic       ready;
  logic       func;
  logic [7:0] key_pattern;
  logic [7:0] reader_byte;

  modport source (output valid, output func, output key_pattern, output reader_byte,
                  input ready);
  modport sink   (input valid, input func, input key_pattern, input reader_byte,
                  output ready);
endinterface

interface kcl_out_if;
  logic       valid;
  logic       ready;
  logic [3:0] key_value;
  logic       unlock;
  logic [1:0] lock_mode;
  logic       card_accepted;
  logic       card_rejected;
  logic       code_changed;

  modport source (output valid, output key_value, output unlock, output lock_mode,
                  output card_accepted, output card_rejected, output code_changed,
                  input ready);
  modport sink   (input valid, input key_value, input unlock, input lock_mode,
                  input card_accepted, input card_rejected, input code_changed,
                  output ready);
endinterface

`default_nettype wire

// ----- hdl/kcl_cfg_regs.sv -----
// APB register file holding the expected card ID (two 48-bit registers).
// Depends on kcl_pkg.
`default_nettype none

module kcl_cfg_regs
  import kcl_pkg::*;
(
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  input  wire logic                   psel,
  input  wire logic                   penable,
  input  wire logic                   pwrite,
  input  wire logic [APB_ADDR_W-1:0]  paddr,
  input  wire logic [APB_DATA_W-1:0]  pwdata,
  output logic      [APB_DATA_W-1:0]  prdata,
  output logic                        pready,
  output logic      [CARD_ID_ALL-1:0] card_id_o
);

  logic [CARD_ID_W-1:0] id_high_q, id_high_d;
  logic [CARD_ID_W-1:0] id_low_q, id_low_d;
  logic                 wr_en;
  kcl_reg_e             reg_sel;

  assign pready  = 1'b1;
  assign wr_en   = psel && penable && pwrite && pready;
  assign reg_sel = kcl_reg_e'(paddr[3]);

  always_comb begin
    id_high_d = id_high_q;
    id_low_d  = id_low_q;
    if (wr_en) begin
      unique case (reg_sel)
        REG_CARD_ID_HIGH: id_high_d = pwdata[CARD_ID_W-1:0];
        REG_CARD_ID_LOW:  id_low_d  = pwdata[CARD_ID_W-1:0];
      endcase
    end
  end

  always_comb begin
    unique case (reg_sel)
      REG_CARD_ID_HIGH: prdata = APB_DATA_W'(id_high_q);
      REG_CARD_ID_LOW:  prdata = APB_DATA_W'(id_low_q);
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      id_high_q <= CARD_ID_HIGH_RST;
      id_low_q  <= CARD_ID_LOW_RST;
    end else begin
      id_high_q <= id_high_d;
      id_low_q  <= id_low_d;
    end
  end

  assign card_id_o = {id_high_q, id_low_q};

endmodule

`default_nettype wire

// ----- hdl/kcl_core.sv -----
// Lock state and per-item logic: key decode, digit ring, card compare and
// new-code entry. Produces one result per step. Depends on kcl_pkg.
`default_nettype none

module kcl_core
  import kcl_pkg::*;
#(
  parameter int unsigned CODE_DIGITS   = 4,
  parameter int unsigned CARD_ID_BYTES = 12
) (
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  input  wire logic                   step_i,
  input  wire kcl_item_t              item_i,
  input  wire logic [CARD_ID_ALL-1:0] card_id_i,
  output kcl_result_t                 result_o
);

  localparam int unsigned PW = (CODE_DIGITS > 1) ? $clog2(CODE_DIGITS) : 1;
  localparam int unsigned CW = (CARD_ID_BYTES > 1) ? $clog2(CARD_ID_BYTES) : 1;
  localparam logic [PW-1:0] POS_LAST  = PW'(CODE_DIGITS - 1);
  localparam logic [CW-1:0] BYTE_LAST = CW'(CARD_ID_BYTES - 1);

  typedef logic [CODE_DIGITS-1:0][3:0] digits_t;

  digits_t       entered_q, entered_d;
  digits_t       stored_q, stored_d;
  digits_t       new_q, new_d;
  logic [PW-1:0] wpos_q, wpos_d;
  logic [PW-1:0] ncnt_q, ncnt_d;
  logic [CW-1:0] bcnt_q, bcnt_d;
  logic          match_q, match_d;
  kcl_mode_e     mode_q, mode_d;

  logic [3:0]    key;
  logic          byte_ok;
  logic          accepted, rejected, changed;

  assign byte_ok = item_i.reader_byte == expected_byte(card_id_i, 4'(bcnt_q));

  always_comb begin
    entered_d = entered_q;
    stored_d  = stored_q;
    new_d     = new_q;
    wpos_d    = wpos_q;
    ncnt_d    = ncnt_q;
    bcnt_d    = bcnt_q;
    match_d   = match_q;
    mode_d    = mode_q;
    key       = NO_KEY;
    accepted  = 1'b0;
    rejected  = 1'b0;
    changed   = 1'b0;

    if (!item_i.func) begin
      key = decode_key(item_i.key_pattern);
      unique case (mode_q)
        MODE_NEWCODE: begin
          if (key <= MAX_DIGIT) begin
            new_d[ncnt_q] = key;
            if (ncnt_q == POS_LAST) begin
              stored_d = new_d;
              ncnt_d   = '0;
              mode_d   = MODE_NORMAL;
              changed  = 1'b1;
            end else begin
              ncnt_d = ncnt_q + 1'b1;
            end
          end
        end
        MODE_CARD: begin
          // pattern is reported only
        end
        default: begin
          priority if (key <= MAX_DIGIT) begin
            entered_d[wpos_q] = key;
            wpos_d = (wpos_q == POS_LAST) ? '0 : wpos_q + 1'b1;
          end else if (key == KEY_CLEAR) begin
            entered_d = '0;
            wpos_d    = '0;
          end else if (key == KEY_CARD) begin
            mode_d  = MODE_CARD;
            bcnt_d  = '0;
            match_d = 1'b1;
          end else begin
            // drop patterns that decode to no key
          end
        end
      endcase
    end else if (mode_q == MODE_CARD) begin
      if (bcnt_q == BYTE_LAST) begin
        if (match_q && byte_ok) begin
          accepted = 1'b1;
          mode_d   = MODE_NEWCODE;
          ncnt_d   = '0;
        end else begin
          rejected = 1'b1;
          mode_d   = MODE_NORMAL;
        end
        bcnt_d  = '0;
        match_d = 1'b1;
      end else begin
        bcnt_d  = bcnt_q + 1'b1;
        match_d = match_q && byte_ok;
      end
    end
  end

  always_comb begin
    result_o.key_value     = key;
    result_o.unlock        = entered_d == stored_d;
    result_o.lock_mode     = mode_d;
    result_o.card_accepted = accepted;
    result_o.card_rejected = rejected;
    result_o.code_changed  = changed;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      entered_q <= '0;
      stored_q  <= {CODE_DIGITS{CODE_RST}};
      wpos_q    <= '0;
      ncnt_q    <= '0;
      bcnt_q    <= '0;
      match_q   <= 1'b1;
      mode_q    <= MODE_NORMAL;
    end else if (step_i) begin
      entered_q <= entered_d;
      stored_q  <= stored_d;
      wpos_q    <= wpos_d;
      ncnt_q    <= ncnt_d;
      bcnt_q    <= bcnt_d;
      match_q   <= match_d;
      mode_q    <= mode_d;
    end
  end

  // New-code digits are written before they are read; no reset.
  always_ff @(posedge clk_i) begin
    if (step_i) begin
      new_q <= new_d;
    end
  end

endmodule

`default_nettype wire

// ----- hdl/keypad_code_lock_with_card_reset_top.sv -----
// Keypad code lock with card reset: input register, lock core, result register.
// Each input item is a keypad scan pattern or a card reader byte; each gives
// exactly one result item with the decoded key, unlock flag and lock mode.
// Channels: in_i (valid/ready sink) and out_o (valid/ready source); the card ID
// is set over the APB port (card_id_high at 0x0, card_id_low at 0x8).
// Path: an accepted item is held in the input register, passes the core logic
// once the result register is free, and its result is held there until taken.
// Throughput: one item per cycle while out_o.ready is high; the state update is
// a single pass of decode and compare logic between the two registers.
// Stall: while out_o.ready is low the result is held; one more item waits in
// the input register, then in_i.ready drops until the result is taken.
// Reset (rst_ni low, asynchronous): both registers empty, ring cleared, every
// stored code digit 1, normal mode, card ID registers at their defaults.
// Depends on kcl_pkg, kcl_if, kcl_cfg_regs and kcl_core.
`default_nettype none

module keypad_code_lock_with_card_reset_top
  import kcl_pkg::*;
#(
  parameter int unsigned CODE_DIGITS   = 4,
  parameter int unsigned CARD_ID_BYTES = 12
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  kcl_in_if.sink                     in_i,
  kcl_out_if.source                  out_o,
  input  wire logic                  psel,
  input  wire logic                  penable,
  input  wire logic                  pwrite,
  input  wire logic [APB_ADDR_W-1:0] paddr,
  input  wire logic [APB_DATA_W-1:0] pwdata,
  output logic      [APB_DATA_W-1:0] prdata,
  output logic                       pready
);

  logic [CARD_ID_ALL-1:0] card_id;
  kcl_item_t              item_q, item_d;
  kcl_result_t            res_q, res_d;
  logic                   item_vld_q, item_vld_d;
  logic                   res_vld_q, res_vld_d;
  logic                   res_free, step, in_fire;

  kcl_cfg_regs u_cfg (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready),
    .card_id_o(card_id)
  );

  assign res_free   = !res_vld_q || out_o.ready;
  assign step       = item_vld_q && res_free;
  assign in_i.ready = !item_vld_q || res_free;
  assign in_fire    = in_i.valid && in_i.ready;

  kcl_core #(
    .CODE_DIGITS  (CODE_DIGITS),
    .CARD_ID_BYTES(CARD_ID_BYTES)
  ) u_core (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .step_i   (step),
    .item_i   (item_q),
    .card_id_i(card_id),
    .result_o (res_d)
  );

  always_comb begin
    item_d.func        = in_i.func;
    item_d.key_pattern = in_i.key_pattern;
    item_d.reader_byte = in_i.reader_byte;
    item_vld_d         = in_fire ? 1'b1 : (step ? 1'b0 : item_vld_q);
    res_vld_d          = step ? 1'b1 : (out_o.ready ? 1'b0 : res_vld_q);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      item_vld_q <= 1'b0;
      res_vld_q  <= 1'b0;
    end else begin
      item_vld_q <= item_vld_d;
      res_vld_q  <= res_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      item_q <= item_d;
    end
    if (step) begin
      res_q <= res_d;
    end
  end

  assign out_o.valid         = res_vld_q;
  assign out_o.key_value     = res_q.key_value;
  assign out_o.unlock        = res_q.unlock;
  assign out_o.lock_mode     = res_q.lock_mode;
  assign out_o.card_accepted = res_q.card_accepted;
  assign out_o.card_rejected = res_q.card_rejected;
  assign out_o.code_changed  = res_q.code_changed;

endmodule

`default_nettype wire

// ----- hdl/kcl_checker.sv -----
// Port-level checks for the keypad code lock, bound to the top level.
// Depends on kcl_pkg for key and mode codes.
`default_nettype none

module kcl_checker
  import kcl_pkg::*;
(
  input wire logic       clk_i,
  input wire logic       rst_ni,
  input wire logic       out_valid_i,
  input wire logic       out_ready_i,
  input wire logic [3:0] key_value_i,
  input wire logic       unlock_i,
  input wire logic [1:0] lock_mode_i,
  input wire logic       card_accepted_i,
  input wire logic       card_rejected_i,
  input wire logic       code_changed_i
);

  // Hold a stalled result item.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(key_value_i)
      && $stable(unlock_i) && $stable(lock_mode_i) && $stable(code_changed_i))
    else $error("stalled result item changed");

  // A card verdict comes from a reader byte, so no key is reported.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && (card_accepted_i || card_rejected_i) |->
      key_value_i == NO_KEY && !(card_accepted_i && card_rejected_i))
    else $error("bad card verdict");

  // Verdicts and code change leave the mode they imply.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |->
      (!card_accepted_i || lock_mode_i == MODE_NEWCODE) &&
      (!card_rejected_i || lock_mode_i == MODE_NORMAL) &&
      (!code_changed_i || lock_mode_i == MODE_NORMAL))
    else $error("mode does not follow event");

  // A changed code is entered from a digit key, never from a reader byte.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && code_changed_i |-> key_value_i <= MAX_DIGIT)
    else $error("code changed without digit key");

endmodule

bind keypad_code_lock_with_card_reset_top kcl_checker u_kcl_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .out_valid_i    (out_o.valid),
  .out_ready_i    (out_o.ready),
  .key_value_i    (out_o.key_value),
  .unlock_i       (out_o.unlock),
  .lock_mode_i    (out_o.lock_mode),
  .card_accepted_i(out_o.card_accepted),
  .card_rejected_i(out_o.card_rejected),
  .code_changed_i (out_o.code_changed)
);

`default_nettype wire
